@@ rtl/bayer_bggr_bilinear_demosaic_defines.svh @@
// Assertion macros for the BGGR demosaic block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BAYER_BGGR_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_BGGR_BILINEAR_DEMOSAIC_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define BDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define BDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bdm_pkg.sv @@
// Shared types and constants for the BGGR bilinear demosaic block.
// No dependencies; used by every file of the block but bdm_ram and the defines.
`default_nettype none

package bdm_pkg;

    // Default size limits and register reset values
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int WIDTH_RESET    = 1280;
    localparam int HEIGHT_RESET   = 1023;
    localparam int WIDTH_MIN      = 4;
    localparam int HEIGHT_MIN     = 2;

    // Configuration port
    localparam int CFG_DW = 12;
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 1'b1;

    localparam int PIX_W   = 8;
    localparam int Q_DEPTH = 2;

    typedef logic [PIX_W-1:0] pix_t;

    // One window column, index 0 is the top row
    typedef logic [2:0][PIX_W-1:0] win_col_t;

    // Window column select
    typedef enum logic [1:0] {
        COL_LEFT  = 2'd0,
        COL_MID   = 2'd1,
        COL_RIGHT = 2'd2
    } col_sel_t;

    // Command from the front to the back for one item
    typedef struct packed {
        logic     shift;      // load a new column into the window
        logic     wr;         // store the sample into the line store
        logic     bank;       // line store bank holding the top row
        pix_t     pix;        // incoming sample
        logic     bot_mid;    // bottom row repeats the middle row (drain)
        logic     emit;       // this item produces a result
        col_sel_t cc;         // center column
        col_sel_t lc;         // left neighbor column
        col_sel_t rc;         // right neighbor column
        logic     top_clamp;  // top neighbor clamped to center row
        logic     bot_clamp;  // bottom neighbor clamped to center row
        logic     x_even;
        logic     y_even;
        logic     last;
    } bdm_cmd_t;

endpackage

`default_nettype wire

@@ rtl/bdm_if.sv @@
// Stream interfaces: raw Bayer items in, RGB items out.
// Depends on bdm_pkg.
`default_nettype none

interface bdm_pix_if;
    import bdm_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    pix_t raw_pixel;

    modport source (output valid, output kind, output raw_pixel, input ready);
    modport sink   (input valid, input kind, input raw_pixel, output ready);
endinterface

interface bdm_rgb_if;
    import bdm_pkg::*;

    logic valid;
    logic ready;
    pix_t red;
    pix_t green;
    pix_t blue;
    logic last_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output last_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/bdm_ram.sv @@
// Generic single-port RAM, read-before-write, registered read data.
// No dependencies.
`default_nettype none

module bdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rd_data_reg <= mem[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/bdm_front.sv @@
// Front end: configuration registers, frame position counters and item
// classification into back-end commands. Depends on bdm_pkg, bdm_if.
`default_nettype none

module bdm_front #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bdm_pix_if.sink                               pix_in,
    input  wire logic                             wr_en,
    input  wire logic [bdm_pkg::CFG_IW-1:0]       wr_index,
    input  wire logic [bdm_pkg::CFG_DW-1:0]       wr_data,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output bdm_pkg::bdm_cmd_t                     q_cmd,
    output logic      [$clog2(MAX_WIDTH)-1:0]     q_addr
);
    import bdm_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WW-1:0] width_reg,  width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [CW-1:0] col_reg,    col_next;
    logic [RW-1:0] row_reg,    row_next;

    logic          accept;
    logic          is_drain;
    logic [RW-1:0] h_ext;
    logic          in_frame;
    logic          final_tick;
    logic          act;
    logic          col_zero;
    logic          col_one;
    logic          end_emit;
    logic          mid_emit;
    logic          col_wrap;
    logic [WW-1:0] wsat;
    logic [HW-1:0] hsat;

    assign pix_in.ready = !q_full;
    assign accept       = pix_in.valid && pix_in.ready;
    assign is_drain     = pix_in.kind;

    // Position classification
    assign h_ext      = RW'(height_reg);
    assign in_frame   = row_reg < h_ext;
    assign final_tick = is_drain && (row_reg > h_ext);
    assign act        = is_drain ? !in_frame : in_frame;
    assign col_zero   = col_reg == '0;
    assign col_one    = col_reg == CW'(1);
    // Last column of the row two above (also the final drain tick)
    assign end_emit   = col_zero && (row_reg >= RW'(2));
    // Previous column of the row above
    assign mid_emit   = !col_zero && (row_reg != '0);
    assign col_wrap   = ({1'b0, col_reg} + (CW+1)'(1)) >= (CW+1)'(width_reg);

    // Register write saturation
    always_comb
    begin
        if (wr_data < CFG_DW'(WIDTH_MIN))
            wsat = WW'(WIDTH_MIN);
        else if (int'(wr_data) > MAX_WIDTH)
            wsat = WW'(MAX_WIDTH);
        else
            wsat = WW'(wr_data);

        if (wr_data < CFG_DW'(HEIGHT_MIN))
            hsat = HW'(HEIGHT_MIN);
        else if (int'(wr_data) > MAX_HEIGHT)
            hsat = HW'(MAX_HEIGHT);
        else
            hsat = HW'(wr_data);
    end

    // Command build
    always_comb
    begin
        q_cmd.shift     = !final_tick;
        q_cmd.wr        = !is_drain;
        q_cmd.bank      = row_reg[0];
        q_cmd.pix       = pix_in.raw_pixel;
        q_cmd.bot_mid   = is_drain;
        q_cmd.emit      = end_emit || mid_emit;
        q_cmd.cc        = final_tick ? COL_RIGHT : COL_MID;
        if (final_tick)
        begin
            q_cmd.lc = COL_MID;
            q_cmd.rc = COL_RIGHT;
        end
        else if (end_emit)
        begin
            // Pre-shift columns 1 and 2 sit at 0 and 1 after the shift
            q_cmd.lc = COL_LEFT;
            q_cmd.rc = COL_MID;
        end
        else
        begin
            q_cmd.lc = col_one ? COL_MID : COL_LEFT;
            q_cmd.rc = COL_RIGHT;
        end
        q_cmd.top_clamp = end_emit ? (row_reg == RW'(2)) : (row_reg == RW'(1));
        q_cmd.bot_clamp = end_emit ? (row_reg > h_ext) : (row_reg >= h_ext);
        q_cmd.x_even    = end_emit ? width_reg[0] : col_reg[0];
        q_cmd.y_even    = end_emit ? !row_reg[0] : row_reg[0];
        q_cmd.last      = final_tick;
        q_addr          = col_reg;
        q_push          = accept && act;
    end

    // Counter and register next state
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH:  width_next  = wsat;
                REG_HEIGHT: height_next = hsat;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept && act)
        begin
            if (final_tick)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bdm_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on bdm_pkg.
`default_nettype none

module bdm_queue #(
    parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire bdm_pkg::bdm_cmd_t            push_cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] push_addr,
    input  wire logic                         pop,
    output logic                              full,
    output logic                              head_valid,
    output bdm_pkg::bdm_cmd_t                 head_cmd,
    output logic      [$clog2(MAX_WIDTH)-1:0] head_addr
);
    import bdm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int NW = $clog2(Q_DEPTH + 1);

    bdm_cmd_t      cmd_mem  [Q_DEPTH];
    logic [CW-1:0] addr_mem [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg,  count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = count_reg == NW'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_addr  = addr_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem[wr_ptr_reg]  <= push_cmd;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bdm_back.sv @@
// Back end: two-row line store, 3x3 window and bilinear color math with
// the output register. Depends on bdm_pkg, bdm_if, bdm_ram.
`default_nettype none

module bdm_back #(
    parameter int MAX_WIDTH = bdm_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire bdm_pkg::bdm_cmd_t            q_cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] q_addr,
    output logic                              q_pop,
    bdm_rgb_if.source                         rgb_out
);
    import bdm_pkg::*;

    logic     adv;
    logic     ram_en;
    pix_t     rd0;
    pix_t     rd1;

    logic     b1_valid_reg;
    bdm_cmd_t b1_cmd_reg;

    win_col_t col0_reg, col1_reg, col2_reg;
    win_col_t s0, s1, s2;
    win_col_t cv, lv, rv;
    pix_t     top_pix, mid_pix, bot_pix;

    logic [1:0]       tr, br;
    logic [PIX_W:0]   hor, ver;
    logic [PIX_W+1:0] dia, gsum;
    pix_t             red_c, green_c, blue_c;

    logic             out_valid_reg;
    pix_t             red_reg, green_reg, blue_reg;
    logic             last_reg;

    function automatic win_col_t pick(col_sel_t s, win_col_t a, win_col_t b, win_col_t c);
        win_col_t r;
        unique case (s)
            COL_LEFT:  r = a;
            COL_MID:   r = b;
            COL_RIGHT: r = c;
            default:   r = c;
        endcase
        return r;
    endfunction

    // Whole back end moves when the output register can take a new item
    assign adv    = !out_valid_reg || rgb_out.ready;
    assign q_pop  = q_valid && adv;
    assign ram_en = q_pop && q_cmd.shift;

    // Line store: bank 0 holds even rows, bank 1 odd rows
    bdm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .clk   (clk),
        .en    (ram_en),
        .we    (q_cmd.wr && !q_cmd.bank),
        .addr  (q_addr),
        .wdata (q_cmd.pix),
        .rdata (rd0)
    );

    bdm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .clk   (clk),
        .en    (ram_en),
        .we    (q_cmd.wr && q_cmd.bank),
        .addr  (q_addr),
        .wdata (q_cmd.pix),
        .rdata (rd1)
    );

    // New window column and shifted window
    assign top_pix = b1_cmd_reg.bank ? rd1 : rd0;
    assign mid_pix = b1_cmd_reg.bank ? rd0 : rd1;
    assign bot_pix = b1_cmd_reg.bot_mid ? mid_pix : b1_cmd_reg.pix;

    assign s0 = b1_cmd_reg.shift ? col1_reg : col0_reg;
    assign s1 = b1_cmd_reg.shift ? col2_reg : col1_reg;
    assign s2 = b1_cmd_reg.shift ? {bot_pix, mid_pix, top_pix} : col2_reg;

    // Neighbor sums and color selection
    always_comb
    begin
        cv   = pick(b1_cmd_reg.cc, s0, s1, s2);
        lv   = pick(b1_cmd_reg.lc, s0, s1, s2);
        rv   = pick(b1_cmd_reg.rc, s0, s1, s2);
        tr   = b1_cmd_reg.top_clamp ? 2'd1 : 2'd0;
        br   = b1_cmd_reg.bot_clamp ? 2'd1 : 2'd2;
        hor  = {1'b0, lv[1]} + {1'b0, rv[1]};
        ver  = {1'b0, cv[tr]} + {1'b0, cv[br]};
        dia  = {2'b00, lv[tr]} + {2'b00, rv[tr]} + {2'b00, lv[br]} + {2'b00, rv[br]};
        gsum = {1'b0, hor} + {1'b0, ver};
        unique case ({b1_cmd_reg.y_even, b1_cmd_reg.x_even})
            2'b11:
            begin
                blue_c  = cv[1];
                green_c = gsum[PIX_W+1:2];
                red_c   = dia[PIX_W+1:2];
            end
            2'b00:
            begin
                red_c   = cv[1];
                green_c = gsum[PIX_W+1:2];
                blue_c  = dia[PIX_W+1:2];
            end
            2'b10:
            begin
                green_c = cv[1];
                blue_c  = hor[PIX_W:1];
                red_c   = ver[PIX_W:1];
            end
            2'b01:
            begin
                green_c = cv[1];
                red_c   = hor[PIX_W:1];
                blue_c  = ver[PIX_W:1];
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col0_reg      <= '0;
            col1_reg      <= '0;
            col2_reg      <= '0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= q_valid;
            out_valid_reg <= b1_valid_reg && b1_cmd_reg.emit;
            if (b1_valid_reg)
            begin
                col0_reg <= s0;
                col1_reg <= s1;
                col2_reg <= s2;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_cmd_reg <= q_cmd;
        end
        if (adv && b1_valid_reg && b1_cmd_reg.emit)
        begin
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            last_reg  <= b1_cmd_reg.last;
        end
    end

    assign rgb_out.valid         = out_valid_reg;
    assign rgb_out.red           = red_reg;
    assign rgb_out.green         = green_reg;
    assign rgb_out.blue          = blue_reg;
    assign rgb_out.last_of_frame = last_reg;

endmodule

`default_nettype wire

@@ rtl/bayer_bggr_bilinear_demosaic.sv @@
// BGGR Bayer to RGB24 bilinear demosaic, top level.
// Usage:
//   pix_in carries raw 8-bit samples in raster order (kind 0) and drain
//   ticks (kind 1); rgb_out carries one RGB item per frame position.
//   Frame size is set through wr_en/wr_index/wr_data (0 = width,
//   1 = height); a write also restarts the frame position.
//   The pixel at (x, y) is produced when the sample at (x+1, y+1) arrives
//   (a row's last pixel by the first sample of row y+2); after a full
//   frame, width+1 drain ticks flush the rest, the last one flagged.
//   Pixels past a full frame and early drain ticks are dropped silently.
//   Path: command queue, window stage register, output register.
//   Throughput: 1 item per cycle when not stalled, set by the single-port
//   line store banks (a read and a write each) feeding the window stage.
//   Reset: width 1280, height 1023, position and window cleared; the line
//   store is not cleared (its unwritten entries never reach a result).
//   Stall: when rgb_out.ready is low the back end holds; a two-entry
//   command queue takes up to two more items, then pix_in.ready drops.
// Depends on bdm_pkg, bdm_if, bdm_front, bdm_queue, bdm_back.
`default_nettype none
`include "bayer_bggr_bilinear_demosaic_defines.svh"

module bayer_bggr_bilinear_demosaic #(
    parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    bdm_pix_if.sink                         pix_in,
    bdm_rgb_if.source                       rgb_out,
    input  wire logic                       wr_en,
    input  wire logic [bdm_pkg::CFG_IW-1:0] wr_index,
    input  wire logic [bdm_pkg::CFG_DW-1:0] wr_data
);
    import bdm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          q_full;
    logic          q_push;
    bdm_cmd_t      q_cmd;
    logic [CW-1:0] q_addr;
    logic          q_pop;
    logic          head_valid;
    bdm_cmd_t      head_cmd;
    logic [CW-1:0] head_addr;

    // Classification and frame position
    bdm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_addr   (q_addr)
    );

    // Decoupling queue
    bdm_queue #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_addr  (q_addr),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_addr  (head_addr)
    );

    // Line store, window and color math
    bdm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_cmd   (head_cmd),
        .q_addr  (head_addr),
        .q_pop   (q_pop),
        .rgb_out (rgb_out)
    );

    // Checks
    `BDM_ASSERT_NOW(a_q_no_overflow, q_push, !q_full, "command pushed into a full queue")
    `BDM_ASSERT_NOW(a_noshift_is_final, q_push && !q_cmd.shift, q_cmd.last && q_cmd.emit, "window hold without final flush")
    `BDM_ASSERT_NEXT(a_restart_after_last, q_push && q_cmd.last, !(q_push && q_cmd.emit), "frame did not restart after last item")

endmodule

`default_nettype wire

@@ tb/bayer_bggr_bilinear_demosaic_tb.sv @@
// Testbench for the BGGR bilinear demosaic block: it drives the raw pixel stream and
// checks every RGB item against a bit-accurate predictor of its own.
// Depends on bdm_pkg, bdm_if and the bayer_bggr_bilinear_demosaic RTL.
`timescale 1ns / 100ps

module bayer_bggr_bilinear_demosaic_tb;
    import bdm_pkg::*;

    localparam int LINE_LEN = MAX_WIDTH_DEF;
    localparam int MAX_ROWS = MAX_HEIGHT_DEF;

    // Item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Sample fill patterns
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_EXTREME = 1;
    localparam int FILL_FLAT    = 2;

    typedef struct {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic last;
    } rgb_expect_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [CFG_IW-1:0] wr_index;
    logic [CFG_DW-1:0] wr_data;

    bdm_pix_if pix_ch ();
    bdm_rgb_if rgb_ch ();

    bayer_bggr_bilinear_demosaic dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_ch),
        .rgb_out  (rgb_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Idle and stall rates, in percent, and the receiver hold-off counter
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int error_count  = 0;

    rgb_expect_t pending_rgb[$];

    // Predictor state
    pix_t        line_bank [2][LINE_LEN];
    pix_t        window_px [3][3];
    int unsigned in_x, in_y, out_x, out_y;
    int unsigned frame_w, frame_h;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: long hold-off when asked, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rgb_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            rgb_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void clear_predictor();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                window_px[r][c] = '0;
        for (int b = 0; b < 2; b++)
            for (int c = 0; c < LINE_LEN; c++)
                line_bank[b][c] = '0;
        in_x    = 0;
        in_y    = 0;
        out_x   = 0;
        out_y   = 0;
        frame_w = WIDTH_RESET;
        frame_h = HEIGHT_RESET;
    endfunction

    // Register write: clamp the size, restart the frame, keep stored samples
    function automatic void apply_frame_size(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        int unsigned v;
        v = val;
        if (idx == REG_WIDTH)
            frame_w = (v < WIDTH_MIN) ? WIDTH_MIN : (v > LINE_LEN) ? LINE_LEN : v;
        else
            frame_h = (v < HEIGHT_MIN) ? HEIGHT_MIN : (v > MAX_ROWS) ? MAX_ROWS : v;
        in_x  = 0;
        in_y  = 0;
        out_x = 0;
        out_y = 0;
    endfunction

    function automatic void shift_window(pix_t top, pix_t mid, pix_t bot);
        pix_t col [3];
        col[0] = top;
        col[1] = mid;
        col[2] = bot;
        for (int r = 0; r < 3; r++)
        begin
            window_px[r][0] = window_px[r][1];
            window_px[r][1] = window_px[r][2];
            window_px[r][2] = col[r];
        end
    endfunction

    // Interpolate the pixel at (out_x, out_y) from the window, queue it, advance
    function automatic void queue_rgb_pixel(col_sel_t cc, col_sel_t lc, col_sel_t rc);
        int unsigned top_r, bot_r, ctr, hor, ver, dia;
        logic        x_even, y_even;
        rgb_expect_t e;
        top_r = (out_y == 0) ? 1 : 0;
        bot_r = (out_y + 1 >= frame_h) ? 1 : 2;
        ctr = window_px[1][cc];
        hor = window_px[1][lc];
        hor += window_px[1][rc];
        ver = window_px[top_r][cc];
        ver += window_px[bot_r][cc];
        dia = window_px[top_r][lc];
        dia += window_px[top_r][rc];
        dia += window_px[bot_r][lc];
        dia += window_px[bot_r][rc];
        x_even = (out_x % 2 == 0);
        y_even = (out_y % 2 == 0);
        if (y_even && x_even)
        begin
            // blue site
            e.blue  = pix_t'(ctr);
            e.green = pix_t'((hor + ver) >> 2);
            e.red   = pix_t'(dia >> 2);
        end
        else if (!y_even && !x_even)
        begin
            // red site
            e.red   = pix_t'(ctr);
            e.green = pix_t'((hor + ver) >> 2);
            e.blue  = pix_t'(dia >> 2);
        end
        else if (y_even)
        begin
            // green on a blue row
            e.green = pix_t'(ctr);
            e.blue  = pix_t'(hor >> 1);
            e.red   = pix_t'(ver >> 1);
        end
        else
        begin
            // green on a red row
            e.green = pix_t'(ctr);
            e.red   = pix_t'(hor >> 1);
            e.blue  = pix_t'(ver >> 1);
        end
        e.last = (out_y + 1 == frame_h) && (out_x + 1 == frame_w);
        pending_rgb.push_back(e);
        out_x++;
        if (out_x >= frame_w)
        begin
            out_x = 0;
            out_y++;
        end
        if (e.last)
        begin
            in_x  = 0;
            in_y  = 0;
            out_x = 0;
            out_y = 0;
        end
    endfunction

    // Work out the result of one accepted item
    function automatic void predict_demosaic(logic kind, pix_t sample);
        int unsigned c, r;
        pix_t top, mid;
        c = in_x % LINE_LEN;
        r = in_y;
        if (kind == KIND_PIXEL)
        begin
            if (r >= frame_h)
                return;
            if (c == 0 && r >= 2)
                queue_rgb_pixel(COL_RIGHT, COL_MID, COL_RIGHT);
            top = line_bank[r & 1][c];
            mid = line_bank[(r + 1) & 1][c];
            shift_window(top, mid, sample);
            line_bank[r & 1][c] = sample;
            if (c >= 1 && r >= 1)
                queue_rgb_pixel(COL_MID, (c == 1) ? COL_MID : COL_LEFT, COL_RIGHT);
            in_x = c + 1;
            if (in_x >= frame_w)
            begin
                in_x = 0;
                in_y = r + 1;
            end
            return;
        end
        // drain ticks before the frame is full are dropped
        if (r < frame_h)
            return;
        if (r == frame_h)
        begin
            if (c == 0)
                queue_rgb_pixel(COL_RIGHT, COL_MID, COL_RIGHT);
            top = line_bank[frame_h & 1][c];
            mid = line_bank[(frame_h + 1) & 1][c];
            shift_window(top, mid, mid);
            if (c >= 1)
                queue_rgb_pixel(COL_MID, (c == 1) ? COL_MID : COL_LEFT, COL_RIGHT);
            in_x = c + 1;
            if (in_x >= frame_w)
            begin
                in_x = 0;
                in_y = frame_h + 1;
            end
            return;
        end
        queue_rgb_pixel(COL_RIGHT, COL_MID, COL_RIGHT);
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_rgb
        rgb_expect_t want;
        if (rst_n === 1'b1 && rgb_ch.valid === 1'b1 && rgb_ch.ready === 1'b1)
        begin
            if (pending_rgb.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected item r=%0d g=%0d b=%0d last=%0b", $time,
                             rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.last_of_frame);
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (rgb_ch.red !== want.red || rgb_ch.green !== want.green ||
                    rgb_ch.blue !== want.blue || rgb_ch.last_of_frame !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: mismatch exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                                 $time, want.red, want.green, want.blue, want.last,
                                 rgb_ch.red, rgb_ch.green, rgb_ch.blue,
                                 rgb_ch.last_of_frame);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared drive tasks; each starts and ends just after a falling edge
    // ---------------------------------------------------------------

    function automatic pix_t pick_sample(int fill);
        case (fill)
            FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_FLAT:    return pix_t'(100 + $urandom_range(0, 3));
            default:      return pix_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic kind, input pix_t sample);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.kind      <= kind;
        pix_ch.raw_pixel <= sample;
        do
            @(posedge clk);
        while (!(pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1));
        predict_demosaic(kind, sample);
        @(negedge clk);
    endtask

    task automatic send_pixels(input int count, input int fill);
        repeat (count)
            send_item(KIND_PIXEL, pick_sample(fill));
    endtask

    task automatic send_drain(input int count);
        repeat (count)
            send_item(KIND_DRAIN, pix_t'($urandom));
    endtask

    // Stop offering and wait until every expected item has arrived
    task automatic wait_for_results();
        pix_ch.valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(negedge clk);
    endtask

    // Block idle: nothing expected and the pipeline drained of dropped items
    task automatic settle();
        wait_for_results();
        repeat (8)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        apply_frame_size(idx, val);
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        write_reg(REG_WIDTH, CFG_DW'(w));
        write_reg(REG_HEIGHT, CFG_DW'(h));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Smallest frame, full-scale samples, early drain and pixels past the frame
    task automatic test_smallest_frame();
        set_frame(WIDTH_MIN, HEIGHT_MIN);
        send_drain(1);
        send_pixels(frame_w * frame_h, FILL_EXTREME);
        send_pixels(2, FILL_EXTREME);
        send_drain(frame_w + 1);
        send_drain(1);
    endtask

    // Out-of-range sizes clamp to the minimum
    task automatic test_size_clamp();
        set_frame(3, 1);
        send_pixels(frame_w * frame_h, FILL_RANDOM);
        send_drain(frame_w + 1);
        set_frame(0, 0);
        send_pixels(frame_w * frame_h, FILL_FLAT);
        send_drain(frame_w + 1);
    endtask

    // A register write mid-frame restarts the frame position
    task automatic test_restart_mid_frame();
        set_frame(6, 3);
        send_pixels(10, FILL_RANDOM);
        settle();
        write_reg(REG_HEIGHT, CFG_DW'(3));
        send_pixels(frame_w * frame_h, FILL_RANDOM);
        send_drain(frame_w + 1);
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_hold();
        set_frame(16, 6);
        hold_left = 300;
        send_pixels(frame_w * frame_h, FILL_RANDOM);
        send_drain(frame_w + 1);
    endtask

    // Sender stops mid-frame until every result is out, then resumes
    task automatic test_sender_pause();
        set_frame(8, 5);
        send_pixels(20, FILL_RANDOM);
        wait_for_results();
        @(negedge clk);
        send_pixels(frame_w * frame_h - 20, FILL_RANDOM);
        send_drain(frame_w + 1);
    endtask

    // Random small frames: mostly well formed, some cut short or with noise
    task automatic test_random_frames(input int item_goal);
        int sent, w, h, fill, flavor, n;
        sent = 0;
        while (sent < item_goal)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(4, 12);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
            fill   = $urandom_range(FILL_RANDOM, FILL_FLAT);
            flavor = $urandom_range(0, 9);
            settle();
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_WIDTH, CFG_DW'(w));
                write_reg(REG_HEIGHT, CFG_DW'(h));
            end
            else
            begin
                write_reg(REG_HEIGHT, CFG_DW'(h));
                write_reg(REG_WIDTH, CFG_DW'(w));
            end
            // back-to-back frames of the same size in one case out of ten
            repeat ((flavor == 3) ? 2 : 1)
            begin
                n = (flavor == 0) ? $urandom_range(1, w * h - 1) : w * h;
                for (int i = 0; i < n; i++)
                begin
                    if (flavor == 1 && $urandom_range(0, 15) == 0)
                        send_drain(1);
                    send_item(KIND_PIXEL, pick_sample(fill));
                end
                sent += n;
                // a frame cut short gets no drain
                if (flavor != 0)
                begin
                    if (flavor == 2)
                        send_pixels($urandom_range(1, 4), fill);
                    send_drain(w + 1);
                    sent += w + 1;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = '0;
        wr_data          = '0;
        pix_ch.valid     = 1'b0;
        pix_ch.kind      = KIND_PIXEL;
        pix_ch.raw_pixel = '0;
        rgb_ch.ready     = 1'b0;
        clear_predictor();
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct  = 14;
        rx_stall_pct = 62;
        test_smallest_frame();
        test_size_clamp();
        test_restart_mid_frame();
        test_random_frames(600);

        tx_idle_pct  = 62;
        rx_stall_pct = 14;
        test_random_frames(580);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_output_hold();
        test_sender_pause();
        test_random_frames(580);

        settle();
        if (pending_rgb.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("bayer_bggr_bilinear_demosaic_tb: clean");
        else
            $display("bayer_bggr_bilinear_demosaic_tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("bayer_bggr_bilinear_demosaic_tb: errors");
        $finish;
    end

endmodule
